### sv/rlgr_pkg.sv
// ----------------------------------------------------------------------------
// rlgr_pkg
// Shared types and constants of the run-length glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package rlgr_pkg;

    // Field and register widths
    localparam int ADDR_W   = 22;
    localparam int DIM_W    = 11;
    localparam int PITCH_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int CHAR_W   = 8;
    localparam int GLYPH_W  = 8;
    localparam int RUN_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

    // Longest run piece that is rendered
    localparam logic [RUN_W-1:0] MAX_RUN = 7'd64;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TILDE   = 8'h7E;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;

    // Action codes
    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_RUN  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR     = 2'd3;

    // Configuration reset values
    localparam logic [DIM_W-1:0]   RST_DISPLAY_WIDTH  = 11'd240;
    localparam logic [DIM_W-1:0]   RST_DISPLAY_HEIGHT = 11'd240;
    localparam logic [PITCH_W-1:0] RST_LINE_PITCH     = 8'd16;
    localparam logic [COLOR_W-1:0] RST_DRAW_COLOR     = 24'd0;

    // Character classes
    typedef enum logic [2:0] {
        CC_INVALID,
        CC_SPACE,
        CC_TAB,
        CC_NEWLINE,
        CC_RETURN,
        CC_GLYPH
    } char_class_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DEACTIVATE,
        OP_SPACE,
        OP_TAB,
        OP_DIV_CURSOR,
        OP_NEWLINE,
        OP_RETURN,
        OP_WRAP,
        OP_DIV_POS,
        OP_PLACE,
        OP_RUN_INIT,
        OP_RUN_STEP
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic        is_run;
        char_class_t char_class;
        logic        size_ok;
        logic        div_busy;
        logic        glyph_active;
        logic        run_empty;
        logic        count_one;
        logic        draw_phase;
        logic        out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/rlgr_if.sv
// ----------------------------------------------------------------------------
// rlgr_if
// Valid/ready channels of the renderer: input items and pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlgr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_code;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic [7:0] glyph_y_offset;
    logic [6:0] run_length;
    logic       run_continues;

    modport source (
        output valid, action, char_code, glyph_width, glyph_height,
               glyph_y_offset, run_length, run_continues,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, glyph_width, glyph_height,
               glyph_y_offset, run_length, run_continues,
        output ready
    );
endinterface

interface rlgr_pixel_if;
    logic        valid;
    logic        ready;
    logic [21:0] pixel_address;
    logic [23:0] pixel_value;
    logic        last_of_run;

    modport source (
        output valid, pixel_address, pixel_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, pixel_value, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

### sv/rlgr_divider.sv
// ----------------------------------------------------------------------------
// rlgr_divider
// Restoring divider, one quotient bit per cycle: cursor or glyph position by screen width.
// ----------------------------------------------------------------------------
`default_nettype none

module rlgr_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rlgr_pkg::ADDR_W-1:0] dividend,
    input  wire logic [rlgr_pkg::DIM_W-1:0]  divisor,
    output logic                            busy,
    output logic [rlgr_pkg::ADDR_W-1:0]     quotient,
    output logic [rlgr_pkg::DIM_W-1:0]      remainder
);
    import rlgr_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ADDR_W-1:0]    quo_reg;
    logic [DIM_W-1:0]     acc_reg;
    logic [DIM_W-1:0]     div_reg;

    logic [DIM_W:0]       trial;
    logic                 fits;

    // Shift the next dividend bit into the partial remainder
    assign trial = {acc_reg, quo_reg[ADDR_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // Control: count the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(ADDR_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: subtract where the divisor fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            acc_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                acc_reg <= DIM_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                acc_reg <= trial[DIM_W-1:0];
            end
            quo_reg <= {quo_reg[ADDR_W-2:0], fits};
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

endmodule

`default_nettype wire

### sv/rlgr_ctrl.sv
// ----------------------------------------------------------------------------
// rlgr_ctrl
// Controller state machine: sequences each item through the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rlgr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire rlgr_pkg::dp_status_t status,
    output rlgr_pkg::dp_op_t          op
);
    import rlgr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLASS,
        S_WAIT_NL,
        S_WAIT_CR,
        S_WAIT_G1,
        S_DIV_POS,
        S_WAIT_G2,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (status.is_run)
                begin
                    state_next = S_IDLE;
                    if (status.glyph_active)
                    begin
                        op = OP_RUN_INIT;
                        if (!status.run_empty)
                        begin
                            state_next = S_RUN;
                        end
                    end
                end
                else
                begin
                    op         = OP_DEACTIVATE;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                state_next = S_IDLE;
                if (status.size_ok)
                begin
                    case (status.char_class)
                        CC_SPACE:   op = OP_SPACE;
                        CC_TAB:     op = OP_TAB;
                        CC_NEWLINE:
                        begin
                            op         = OP_DIV_CURSOR;
                            state_next = S_WAIT_NL;
                        end
                        CC_RETURN:
                        begin
                            op         = OP_DIV_CURSOR;
                            state_next = S_WAIT_CR;
                        end
                        CC_GLYPH:
                        begin
                            op         = OP_DIV_CURSOR;
                            state_next = S_WAIT_G1;
                        end
                        default:    op = OP_NONE;
                    endcase
                end
            end
            S_WAIT_NL:
            begin
                if (!status.div_busy)
                begin
                    op         = OP_NEWLINE;
                    state_next = S_IDLE;
                end
            end
            S_WAIT_CR:
            begin
                if (!status.div_busy)
                begin
                    op         = OP_RETURN;
                    state_next = S_IDLE;
                end
            end
            S_WAIT_G1:
            begin
                if (!status.div_busy)
                begin
                    op         = OP_WRAP;
                    state_next = S_DIV_POS;
                end
            end
            S_DIV_POS:
            begin
                op         = OP_DIV_POS;
                state_next = S_WAIT_G2;
            end
            S_WAIT_G2:
            begin
                if (!status.div_busy)
                begin
                    op         = OP_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                // Advance one pixel; drawn pixels wait for a free output register
                if (!status.draw_phase || status.out_free)
                begin
                    op = OP_RUN_STEP;
                    if (status.count_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### sv/rlgr_datapath.sv
// ----------------------------------------------------------------------------
// rlgr_datapath
// Configuration, cursor and glyph state, pixel address generation and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlgr_datapath #(
    parameter int TAB_WIDTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [rlgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rlgr_pkg::COLOR_W-1:0]   cfg_data,
    input  wire logic                          action,
    input  wire logic [rlgr_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [rlgr_pkg::GLYPH_W-1:0]   glyph_width,
    input  wire logic [rlgr_pkg::GLYPH_W-1:0]   glyph_height,
    input  wire logic [rlgr_pkg::GLYPH_W-1:0]   glyph_y_offset,
    input  wire logic [rlgr_pkg::RUN_W-1:0]     run_length,
    input  wire logic                          run_continues,
    input  wire rlgr_pkg::dp_op_t              op,
    output rlgr_pkg::dp_status_t               status,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rlgr_pkg::ADDR_W-1:0]         pixel_address,
    output logic [rlgr_pkg::COLOR_W-1:0]        pixel_value,
    output logic                               last_of_run
);
    import rlgr_pkg::*;

    localparam int TAB_BITS = $clog2(TAB_WIDTH + 1);
    localparam int TAB_ADV_W = GLYPH_W + TAB_BITS;
    localparam logic [TAB_BITS-1:0] TAB_MULT = TAB_BITS'(TAB_WIDTH);

    // Configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [COLOR_W-1:0] color_reg;

    // Latched item fields
    logic               action_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [GLYPH_W-1:0] gw_reg;
    logic [GLYPH_W-1:0] gh_reg;
    logic [GLYPH_W-1:0] yoff_reg;
    logic [RUN_W-1:0]   len_reg;
    logic               cont_reg;

    // Products of latched fields and configuration
    logic [2*GLYPH_W-1:0]     glyph_area_reg;
    logic [2*DIM_W-1:0]       screen_area_reg;
    logic [TAB_ADV_W-1:0]     tab_adv_reg;
    logic [DIM_W+PITCH_W-1:0] pitch_w_reg;
    logic [DIM_W+GLYPH_W-1:0] yoff_w_reg;

    // Render state
    logic [ADDR_W-1:0]  cursor_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [GLYPH_W-1:0] fill_reg;
    logic [GLYPH_W-1:0] rowlen_reg;
    logic               phase_reg;
    logic               active_reg;
    logic               started_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [RUN_W-1:0]   count_reg;

    // Output register
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] value_reg;
    logic               last_reg;

    // Combinational helpers
    logic [DIM_W-1:0]     w_eff;
    char_class_t          char_class;
    logic                 div_start;
    logic                 div_busy;
    logic [ADDR_W-1:0]    div_q;
    logic [DIM_W-1:0]     div_r;
    logic [ADDR_W-1:0]    nl_sum;
    logic [ADDR_W+DIM_W-1:0] nl_prod;
    logic                 wrap_h;
    logic [ADDR_W-1:0]    wrap_pos;
    logic                 wrap_v;
    logic [GLYPH_W:0]     fill_inc;
    logic                 out_free;

    // A zero screen width counts as one
    assign w_eff = (width_reg == '0) ? DIM_W'(1) : width_reg;

    // Classify the latched character
    always_comb
    begin
        if (char_reg == CHAR_SPACE)
        begin
            char_class = CC_SPACE;
        end
        else if (char_reg == CHAR_TAB)
        begin
            char_class = CC_TAB;
        end
        else if (char_reg == CHAR_NEWLINE)
        begin
            char_class = CC_NEWLINE;
        end
        else if (char_reg == CHAR_RETURN)
        begin
            char_class = CC_RETURN;
        end
        else if (char_reg > CHAR_SPACE && char_reg <= CHAR_TILDE)
        begin
            char_class = CC_GLYPH;
        end
        else
        begin
            char_class = CC_INVALID;
        end
    end

    // Shared divider: row and column of the cursor or of a wrapped position
    assign div_start = (op == OP_DIV_CURSOR) || (op == OP_DIV_POS);

    rlgr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  ((op == OP_DIV_POS) ? pos_reg : cursor_reg),
        .divisor   (w_eff),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Newline: first column of the row line_pitch rows down
    assign nl_sum  = div_q + ADDR_W'(pitch_reg);
    assign nl_prod = (ADDR_W+DIM_W)'(nl_sum) * (ADDR_W+DIM_W)'(w_eff);

    // Glyph placement: horizontal wrap, then vertical wrap
    assign wrap_h   = ({1'b0, div_r} + (DIM_W+1)'(gw_reg)) > {1'b0, w_eff};
    assign wrap_pos = cursor_reg + ADDR_W'(w_eff - div_r) + ADDR_W'(pitch_w_reg);
    assign wrap_v   = ({1'b0, div_q} + (ADDR_W+1)'(gh_reg)) > (ADDR_W+1)'(height_reg);

    // Next column within the glyph row
    assign fill_inc = {1'b0, fill_reg} + 1'b1;

    assign out_free = !out_valid_reg || out_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_DISPLAY_WIDTH;
            height_reg <= RST_DISPLAY_HEIGHT;
            pitch_reg  <= RST_LINE_PITCH;
            color_reg  <= RST_DRAW_COLOR;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DISPLAY_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_DISPLAY_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_LINE_PITCH:     pitch_reg  <= cfg_data[PITCH_W-1:0];
                CFG_DRAW_COLOR:     color_reg  <= cfg_data;
                default:            color_reg  <= color_reg;
            endcase
        end
    end

    // Latch item fields on transfer and form products
    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
        begin
            action_reg <= action;
            char_reg   <= char_code;
            gw_reg     <= glyph_width;
            gh_reg     <= glyph_height;
            yoff_reg   <= glyph_y_offset;
            len_reg    <= run_length;
            cont_reg   <= run_continues;
        end
        glyph_area_reg  <= gw_reg * gh_reg;
        screen_area_reg <= w_eff * height_reg;
        tab_adv_reg     <= TAB_ADV_W'(gw_reg) * TAB_ADV_W'(TAB_MULT);
        pitch_w_reg     <= (DIM_W+PITCH_W)'(w_eff) * (DIM_W+PITCH_W)'(pitch_reg);
        yoff_w_reg      <= (DIM_W+GLYPH_W)'(w_eff) * (DIM_W+GLYPH_W)'(yoff_reg);
    end

    // Update cursor and glyph state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg  <= '0;
            base_reg    <= '0;
            fill_reg    <= '0;
            rowlen_reg  <= '0;
            phase_reg   <= 1'b0;
            active_reg  <= 1'b0;
            started_reg <= 1'b0;
            pos_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            case (op)
                OP_DEACTIVATE:
                begin
                    active_reg <= 1'b0;
                end
                OP_SPACE:
                begin
                    cursor_reg <= cursor_reg + ADDR_W'(gw_reg);
                end
                OP_TAB:
                begin
                    cursor_reg <= cursor_reg + ADDR_W'(tab_adv_reg);
                end
                OP_NEWLINE:
                begin
                    cursor_reg <= nl_prod[ADDR_W-1:0];
                end
                OP_RETURN:
                begin
                    cursor_reg <= cursor_reg - ADDR_W'(div_r);
                end
                OP_WRAP:
                begin
                    pos_reg <= wrap_h ? wrap_pos : cursor_reg;
                end
                OP_PLACE:
                begin
                    base_reg    <= (wrap_v ? '0 : pos_reg) + ADDR_W'(yoff_w_reg);
                    fill_reg    <= '0;
                    rowlen_reg  <= gw_reg;
                    phase_reg   <= 1'b0;
                    started_reg <= 1'b0;
                    active_reg  <= 1'b1;
                    cursor_reg  <= cursor_reg + ADDR_W'(gw_reg);
                end
                OP_RUN_INIT:
                begin
                    // Toggle parity only between separate runs
                    if (started_reg && !cont_reg)
                    begin
                        phase_reg <= !phase_reg;
                    end
                    started_reg <= 1'b1;
                    count_reg   <= (len_reg > MAX_RUN) ? MAX_RUN : len_reg;
                end
                OP_RUN_STEP:
                begin
                    count_reg <= count_reg - 1'b1;
                    if (fill_inc >= {1'b0, rowlen_reg})
                    begin
                        fill_reg <= '0;
                        base_reg <= base_reg + ADDR_W'(w_eff);
                    end
                    else
                    begin
                        fill_reg <= fill_inc[GLYPH_W-1:0];
                    end
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Hold the pixel until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_RUN_STEP && phase_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_RUN_STEP && phase_reg)
        begin
            addr_reg  <= base_reg + ADDR_W'(fill_reg);
            value_reg <= color_reg;
            last_reg  <= (count_reg == RUN_W'(1));
        end
    end

    // Report status
    always_comb
    begin
        status.is_run       = (action_reg == ACTION_RUN);
        status.char_class   = char_class;
        status.size_ok      = (ADDR_W'(glyph_area_reg) < ADDR_W'(screen_area_reg));
        status.div_busy     = div_busy;
        status.glyph_active = active_reg;
        status.run_empty    = (len_reg == '0);
        status.count_one    = (count_reg == RUN_W'(1));
        status.draw_phase   = phase_reg;
        status.out_free     = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

### sv/run_length_glyph_renderer.sv
// ----------------------------------------------------------------------------
// run_length_glyph_renderer
// Renders run-length encoded glyphs into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A run item steps through its piece (at
// most 64 pixels) pixel by pixel, drawn pixels also waiting on the pixel
// channel. Space, tab and ignored characters need no division; newline and
// carriage return wait for the one-bit-per-cycle divider that finds the
// cursor's row and column, and a printable glyph waits for it twice (two
// divisions per glyph: the cursor, then the wrapped position). The last pixel
// of a run may still wait in the output register while the next item is
// taken.
`default_nettype none

module run_length_glyph_renderer #(
    parameter int TAB_WIDTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [rlgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rlgr_pkg::COLOR_W-1:0]   cfg_data,
    rlgr_item_if.sink                          item,
    rlgr_pixel_if.source                       pixel
);
    import rlgr_pkg::*;

    dp_op_t     op;
    dp_status_t status;
    logic       item_ready;

    // Sequence items
    rlgr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item_ready),
        .status     (status),
        .op         (op)
    );

    // Compute cursor, glyph box and pixel writes
    rlgr_datapath #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (item.action),
        .char_code      (item.char_code),
        .glyph_width    (item.glyph_width),
        .glyph_height   (item.glyph_height),
        .glyph_y_offset (item.glyph_y_offset),
        .run_length     (item.run_length),
        .run_continues  (item.run_continues),
        .op             (op),
        .status         (status),
        .out_valid      (pixel.valid),
        .out_ready      (pixel.ready),
        .pixel_address  (pixel.pixel_address),
        .pixel_value    (pixel.pixel_value),
        .last_of_run    (pixel.last_of_run)
    );

    assign item.ready = item_ready;

endmodule

`default_nettype wire

### sv/rlgr_checker.sv
// ----------------------------------------------------------------------------
// rlgr_checker
// Port-level assertions on the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rlgr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [21:0] out_address,
    input wire logic        out_last
);

    // Hold a stalled pixel
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_address))
        else $error("pixel changed while stalled");

    // Drop ready for the cycle after an item transfer
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken on consecutive cycles");

    // Only the last pixel of a run may wait while new items are taken
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("ready while a run is still drawing");

    // Drawn pixels of one piece follow without a gap
    a_run_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("gap inside a drawn run");

endmodule

bind run_length_glyph_renderer rlgr_checker u_rlgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (pixel.valid),
    .out_ready   (pixel.ready),
    .out_address (pixel.pixel_address),
    .out_last    (pixel.last_of_run)
);

`default_nettype wire

### verif/glyph_pixel_checker.sv
// ----------------------------------------------------------------------------
// glyph_pixel_checker
// Scoreboard for the run-length glyph renderer. It follows the configuration
// port and the item channel, predicts every framebuffer pixel write, and
// compares the pixel channel against the oldest pending write.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_pixel_checker
    import rlgr_pkg::*;
#(
    parameter int TAB_WIDTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    rlgr_item_if                      item,
    rlgr_pixel_if                     pixel,
    output int                        fail_count,
    output int                        writes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_CAP = 100;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        addr_t              address;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_write_t;

    // Pending pixel writes, oldest first
    pixel_write_t writes_due [$];

    // Display setup as last written
    logic [DIM_W-1:0]   scr_width;
    logic [DIM_W-1:0]   scr_height;
    logic [PITCH_W-1:0] pitch_rows;
    logic [COLOR_W-1:0] ink_color;

    // Text cursor and the open glyph box
    addr_t              cur_pos;
    addr_t              box_base;
    logic [GLYPH_W-1:0] col_fill;
    logic [GLYPH_W-1:0] box_row_len;
    logic               inked;
    logic               box_open;
    logic               piece_seen;

    int mismatches = 0;
    int backlog    = 0;

    assign fail_count     = mismatches;
    assign writes_pending = backlog;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] code);
        if (code == CHAR_SPACE)
            return CC_SPACE;
        if (code == CHAR_TAB)
            return CC_TAB;
        if (code == CHAR_NEWLINE)
            return CC_NEWLINE;
        if (code == CHAR_RETURN)
            return CC_RETURN;
        if (code > CHAR_SPACE && code <= CHAR_TILDE)
            return CC_GLYPH;
        return CC_INVALID;
    endfunction

    // Row stride, with a zero width taken as one
    function automatic int unsigned stride();
        return (scr_width == '0) ? 1 : int'(scr_width);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Move the cursor, or open a glyph box for a printable character
    task automatic place_character(input logic [CHAR_W-1:0] code,
                                   input int unsigned gw, input int unsigned gh,
                                   input int unsigned yoff);
        int unsigned w;
        int unsigned pos;
        char_class_t cls;
        w   = stride();
        cls = classify(code);
        box_open = 1'b0;
        if (cls == CC_INVALID)
            return;
        if (!(gw * gh < w * int'(scr_height)))
            return;
        pos = int'(cur_pos);
        case (cls)
            CC_SPACE:   cur_pos = addr_t'(pos + gw);
            CC_TAB:     cur_pos = addr_t'(pos + gw * TAB_WIDTH);
            CC_NEWLINE: cur_pos = addr_t'((pos / w + int'(pitch_rows)) * w);
            CC_RETURN:  cur_pos = addr_t'(pos - pos % w);
            default:
            begin
                // wrap right edge, then bottom edge, then shift down
                if (pos % w + gw > w)
                    pos = int'(addr_t'(pos + (w - pos % w) + w * int'(pitch_rows)));
                if (pos / w + gh > int'(scr_height))
                    pos = 0;
                pos = int'(addr_t'(pos + yoff * w));
                box_base    = addr_t'(pos);
                col_fill    = '0;
                box_row_len = GLYPH_W'(gw);
                inked       = 1'b0;
                piece_seen  = 1'b0;
                box_open    = 1'b1;
                cur_pos     = addr_t'(int'(cur_pos) + gw);
            end
        endcase
    endtask

    // Walk one run piece through the glyph box, queuing the drawn pixels
    task automatic render_run(input int unsigned len, input logic cont);
        int unsigned w;
        int unsigned i;
        bit held_valid;
        pixel_write_t held;
        if (!box_open)
            return;
        w = stride();
        if (piece_seen && !cont)
            inked = !inked;
        piece_seen = 1'b1;
        if (len > int'(MAX_RUN))
            len = int'(MAX_RUN);
        held_valid = 1'b0;
        held = '0;
        for (i = 0; i < len; i++)
        begin
            if (inked)
            begin
                if (held_valid)
                    writes_due.push_back(held);
                held.address = addr_t'(box_base + col_fill);
                held.color   = ink_color;
                held.last    = 1'b0;
                held_valid   = 1'b1;
            end
            col_fill++;
            if (col_fill >= box_row_len)
            begin
                col_fill = '0;
                box_base = addr_t'(int'(box_base) + w);
            end
        end
        // flag the final drawn pixel of the piece
        if (held_valid)
        begin
            held.last = 1'b1;
            writes_due.push_back(held);
        end
    endtask

    task automatic check_write();
        pixel_write_t want;
        if (writes_due.size() == 0)
        begin
            report_mismatch("pixel write with none pending, address",
                            32'(pixel.pixel_address), 32'd0);
            return;
        end
        want = writes_due.pop_front();
        if (pixel.pixel_address !== want.address)
            report_mismatch("pixel_address", 32'(pixel.pixel_address), 32'(want.address));
        if (pixel.pixel_value !== want.color)
            report_mismatch("pixel_value", 32'(pixel.pixel_value), 32'(want.color));
        if (pixel.last_of_run !== want.last)
            report_mismatch("last_of_run", 32'(pixel.last_of_run), 32'(want.last));
    endtask

    // Follow the ports; check outputs before predicting the same edge's input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_width   = RST_DISPLAY_WIDTH;
            scr_height  = RST_DISPLAY_HEIGHT;
            pitch_rows  = RST_LINE_PITCH;
            ink_color   = RST_DRAW_COLOR;
            cur_pos     = '0;
            box_base    = '0;
            col_fill    = '0;
            box_row_len = '0;
            inked       = 1'b0;
            box_open    = 1'b0;
            piece_seen  = 1'b0;
            writes_due.delete();
            backlog <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DISPLAY_WIDTH:  scr_width  = cfg_data[DIM_W-1:0];
                    CFG_DISPLAY_HEIGHT: scr_height = cfg_data[DIM_W-1:0];
                    CFG_LINE_PITCH:     pitch_rows = cfg_data[PITCH_W-1:0];
                    CFG_DRAW_COLOR:     ink_color  = cfg_data;
                    default: ;
                endcase
            end
            if (pixel.valid && pixel.ready)
                check_write();
            if (item.valid && item.ready)
            begin
                if (item.action == ACTION_CHAR)
                    place_character(item.char_code, int'(item.glyph_width),
                                    int'(item.glyph_height), int'(item.glyph_y_offset));
                else
                    render_run(int'(item.run_length), item.run_continues);
            end
            backlog <= writes_due.size();
        end
    end

endmodule

`default_nettype wire

### verif/run_length_glyph_renderer_tb.sv
// ----------------------------------------------------------------------------
// run_length_glyph_renderer_tb
// Top of the renderer testbench. Drives a directed set of character and run
// items, a back-pressure stretch, then randomized glyph sequences under several
// display setups, with bursty input and a stalling pixel sink. Checking is done
// by glyph_pixel_checker; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_glyph_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlgr_pkg::*;

    localparam int TAB_WIDTH     = 4;
    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;

    typedef struct packed {
        logic               action;
        logic [CHAR_W-1:0]  code;
        logic [GLYPH_W-1:0] gw;
        logic [GLYPH_W-1:0] gh;
        logic [GLYPH_W-1:0] yoff;
        logic [RUN_W-1:0]   run_len;
        logic               cont;
    } glyph_item_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_PULSE
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    int mismatch_count;
    int writes_pending;
    int hold_requests = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    int seq_items     = 0;
    bit gaps_on       = 1'b1;

    rlgr_item_if  item_bus ();
    rlgr_pixel_if pixel_bus ();

    run_length_glyph_renderer #(
        .TAB_WIDTH (TAB_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .pixel     (pixel_bus)
    );

    glyph_pixel_checker #(
        .TAB_WIDTH (TAB_WIDTH)
    ) scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item           (item_bus),
        .pixel          (pixel_bus),
        .fail_count     (mismatch_count),
        .writes_pending (writes_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (pixel_bus.valid && pixel_bus.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL run_length_glyph_renderer");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pixel sink: random stall modes in segments, plus requested long hold-offs
    initial
    begin : pixel_sink
        rx_mode_t mode;
        int seg_left;
        int hold_left;
        int holds_seen;
        int tick;
        mode       = RX_FREE;
        seg_left   = 0;
        hold_left  = 0;
        holds_seen = 0;
        tick       = 0;
        pixel_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_bus.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 80);
                end
                seg_left--;
                tick++;
                case (mode)
                    RX_FREE:   pixel_bus.ready <= 1'b1;
                    RX_COIN:   pixel_bus.ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: pixel_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   pixel_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic glyph_item_t char_item(input logic [CHAR_W-1:0] code,
                                              input logic [GLYPH_W-1:0] gw,
                                              input logic [GLYPH_W-1:0] gh,
                                              input logic [GLYPH_W-1:0] yoff);
        glyph_item_t it;
        it.action  = ACTION_CHAR;
        it.code    = code;
        it.gw      = gw;
        it.gh      = gh;
        it.yoff    = yoff;
        it.run_len = RUN_W'($urandom);
        it.cont    = 1'($urandom);
        return it;
    endfunction

    function automatic glyph_item_t run_item(input logic [RUN_W-1:0] len, input logic cont);
        glyph_item_t it;
        it.action  = ACTION_RUN;
        it.code    = CHAR_W'($urandom);
        it.gw      = GLYPH_W'($urandom);
        it.gh      = GLYPH_W'($urandom);
        it.yoff    = GLYPH_W'($urandom);
        it.run_len = len;
        it.cont    = cont;
        return it;
    endfunction

    function automatic glyph_item_t noise_item();
        glyph_item_t it;
        it = run_item(RUN_W'($urandom), 1'($urandom));
        it.action = 1'($urandom);
        return it;
    endfunction

    // Glyph dimension: mostly small, sometimes zero or large
    function automatic logic [GLYPH_W-1:0] rand_dim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 65)
            return GLYPH_W'($urandom_range(1, 16));
        if (sel < 90)
            return GLYPH_W'($urandom_range(17, 64));
        return GLYPH_W'($urandom_range(65, 255));
    endfunction

    // Run length: mostly short pieces, some full and some over the cap
    function automatic logic [RUN_W-1:0] rand_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 75)
            return RUN_W'($urandom_range(1, 12));
        if (sel < 90)
            return RUN_W'($urandom_range(13, 64));
        return RUN_W'($urandom_range(65, 127));
    endfunction

    // Offer one item, with random gaps between bursts, and wait for its transfer
    task automatic send_item(input glyph_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (gaps_on && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        item_bus.valid          <= 1'b1;
        item_bus.action         <= it.action;
        item_bus.char_code      <= it.code;
        item_bus.glyph_width    <= it.gw;
        item_bus.glyph_height   <= it.gh;
        item_bus.glyph_y_offset <= it.yoff;
        item_bus.run_length     <= it.run_len;
        item_bus.run_continues  <= it.cont;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    // Stop offering, wait for every pending pixel write, then let the block go idle
    task automatic drain_and_settle();
        item_bus.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (writes_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_display(input int w, input int h, input int pitch,
                                   input logic [COLOR_W-1:0] color);
        drain_and_settle();
        write_register(CFG_DISPLAY_WIDTH, COLOR_W'(w));
        write_register(CFG_DISPLAY_HEIGHT, COLOR_W'(h));
        write_register(CFG_LINE_PITCH, COLOR_W'(pitch));
        write_register(CFG_DRAW_COLOR, color);
        cfg_write <= 1'b0;
    endtask

    // One character followed by a few run pieces with random content
    task automatic random_glyph_seq();
        int sel;
        logic [CHAR_W-1:0]  code;
        logic [GLYPH_W-1:0] yoff;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            code = CHAR_W'($urandom_range(8'h21, 8'h7E));
        else if (sel < 79)
            code = CHAR_SPACE;
        else if (sel < 83)
            code = CHAR_TAB;
        else if (sel < 87)
            code = CHAR_NEWLINE;
        else if (sel < 90)
            code = CHAR_RETURN;
        else if (sel < 95)
            code = CHAR_W'($urandom_range(8'h7F, 8'hFF));
        else
            code = CHAR_W'($urandom_range(0, 8'h1F));
        yoff = ($urandom_range(0, 4) == 0) ? GLYPH_W'($urandom) :
                                             GLYPH_W'($urandom_range(0, 8));
        send_item(char_item(code, rand_dim(), rand_dim(), yoff));
        seq_items++;
        repeat ($urandom_range(1, 8))
        begin
            send_item(run_item(rand_len(), $urandom_range(0, 3) == 0));
            seq_items++;
        end
    endtask

    // Mostly well-formed glyph sequences, some stray items between them
    task automatic random_phase(input int budget);
        int target;
        target  = seq_items + budget;
        gaps_on = ($urandom_range(0, 3) != 0);
        while (seq_items < target)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(noise_item());
            else
                random_glyph_seq();
        end
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_DISPLAY_WIDTH;
        cfg_data  = '0;
        item_bus.valid          = 1'b0;
        item_bus.action         = ACTION_CHAR;
        item_bus.char_code      = '0;
        item_bus.glyph_width    = '0;
        item_bus.glyph_height   = '0;
        item_bus.glyph_y_offset = '0;
        item_bus.run_length     = '0;
        item_bus.run_continues  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset display setup
        send_item(run_item(7'd10, 1'b0));           // run with no glyph open
        send_item(char_item("A", 8'd8, 8'd12, 8'd2));
        send_item(run_item(7'd5, 1'b1));            // first piece skips anyway
        send_item(run_item(7'd64, 1'b0));           // drawn, spans rows
        send_item(run_item(7'd3, 1'b1));            // continues drawing
        send_item(run_item(7'd0, 1'b0));            // empty skip piece
        send_item(run_item(7'd127, 1'b0));          // cut to the cap
        send_item(char_item(8'h00, 8'd4, 8'd4, 8'd0));
        send_item(run_item(7'd4, 1'b0));            // glyph closed by invalid code
        send_item(char_item(CHAR_SPACE, 8'd255, 8'd1, 8'd0));
        send_item(char_item(CHAR_TAB, 8'd10, 8'd1, 8'd0));
        send_item(char_item(CHAR_RETURN, 8'd0, 8'd0, 8'd0));
        send_item(char_item(CHAR_NEWLINE, 8'd1, 8'd1, 8'd0));
        send_item(char_item(8'h7F, 8'd1, 8'd1, 8'd0));
        send_item(char_item(8'hFF, 8'd1, 8'd1, 8'd0));
        send_item(char_item(CHAR_TILDE, 8'd0, 8'd3, 8'd0));
        send_item(run_item(7'd1, 1'b0));
        send_item(run_item(7'd5, 1'b0));            // zero row length
        send_item(char_item("!", 8'd255, 8'd255, 8'd0));
        send_item(run_item(7'd6, 1'b0));            // oversized glyph ignored
        send_item(char_item(CHAR_TILDE, 8'd200, 8'd200, 8'd255));
        send_item(run_item(7'd2, 1'b0));
        send_item(run_item(7'd64, 1'b0));
        send_item(char_item("Z", 8'd255, 8'd1, 8'd0));
        send_item(run_item(7'd0, 1'b1));
        send_item(run_item(7'd9, 1'b0));

        // Hold the sink off while the sender keeps offering drawn pixels
        program_display(240, 240, 16, 24'hA5C3F0);
        hold_requests <= hold_requests + 1;
        send_item(char_item("M", 8'd16, 8'd16, 8'd0));
        send_item(run_item(7'd0, 1'b0));
        send_item(run_item(7'd64, 1'b0));
        send_item(run_item(7'd64, 1'b1));
        send_item(run_item(7'd10, 1'b0));
        send_item(run_item(7'd64, 1'b0));
        send_item(run_item(7'd64, 1'b1));

        // Random sequences under several display setups
        random_phase(80);
        program_display(1024, 1024, 255, 24'hFFFFFF);
        random_phase(60);
        program_display(1, 1, 0, 24'h000000);
        random_phase(20);
        program_display(0, 7, 3, COLOR_W'($urandom));
        random_phase(20);
        program_display(16, 12, 1, COLOR_W'($urandom));
        random_phase(70);
        program_display($urandom_range(1, 1024), $urandom_range(1, 1024),
                        $urandom_range(0, 255), COLOR_W'($urandom));
        random_phase(50);

        drain_and_settle();
        if (mismatch_count == 0 && writes_pending == 0)
            $display("PASS run_length_glyph_renderer");
        else
            $display("FAIL run_length_glyph_renderer");
        $finish;
    end

endmodule

`default_nettype wire
